[rtl/tqle_pkg.sv]
// Package for the tabular Q-learning engine: word types, opcodes, register
// indexes, table geometry and the saturation helper.
// No dependencies.
package tqle_pkg;

  localparam int Q_W         = 32;
  localparam int TABLE_ROWS  = 256;
  localparam int ROW_SLOTS   = 16;
  localparam int STATE_W     = 8;
  localparam int ACTION_W    = 4;
  localparam int COUNT_W     = 5;
  localparam int RATE_W      = 17;
  localparam int LANES       = 4;
  localparam int LANE_W      = 2;
  localparam int CHUNK_W     = ACTION_W - LANE_W;

  localparam logic [RATE_W-1:0]  RATE_ONE     = 17'd65536;
  localparam logic [RATE_W-1:0]  LEARN_RESET  = 17'd6554;
  localparam logic [RATE_W-1:0]  GAMMA_RESET  = 17'd64881;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = 5'd16;
  localparam logic [COUNT_W-1:0] COUNT_MIN    = 5'd1;

  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_GREEDY = 2'd1;
  localparam logic [1:0] OP_MASKED = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [1:0] CFG_LEARN    = 2'd0;
  localparam logic [1:0] CFG_DISCOUNT = 2'd1;
  localparam logic [1:0] CFG_ACTIONS  = 2'd2;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [STATE_W-1:0]  state_index;
    logic [ACTION_W-1:0] action_index;
    logic signed [31:0]  reward_value;
    logic [STATE_W-1:0]  next_state_index;
    logic [15:0]         legal_mask;
  } req_t;

  typedef struct packed {
    logic [ACTION_W-1:0] chosen_action;
    logic signed [31:0]  q_result;
    logic                error_flag;
  } rsp_t;

  typedef logic [ROW_SLOTS-1:0][Q_W-1:0] row_t;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_SCAN  = 9'b000000100,
    S_FETCH = 9'b000001000,
    S_GMUL  = 9'b000010000,
    S_TGT   = 9'b000100000,
    S_AMUL  = 9'b001000000,
    S_WRITE = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  localparam logic signed [35:0] SAT_HI = 36'sd2147483647;
  localparam logic signed [35:0] SAT_LO = -36'sd2147483648;

  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [35:0] v);
    logic signed [Q_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[Q_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[Q_W-1:0];
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/tabular_q_learning_engine.sv]
// Tabular Q-learning engine: row-wide Q table memory, row scan, update datapath.
// Depends on tqle_pkg.
//
// Usage: request words enter on req/req_valid/req_stall, one result word per
// request leaves on rsp/rsp_valid/rsp_stall. The user must write registers
// (learn rate, discount, actions in use) on cfg_we/cfg_index/cfg_data only
// while idle; the block does not enforce this. The table is one row of 16 Q
// values per state in a single-port-read, single-port-write memory with a
// registered read. The row maximum is scanned four actions per cycle.
// Steps: update scans the next-state row, then GMUL, TGT, AMUL and WRITE;
// greedy and masked greedy scan the row; read passes FETCH; all end in DONE,
// which an out-of-range action reaches at once. One request is in flight at
// a time; a new one is taken in the cycle after the last result is loaded.
// After reset all 256 rows of the table are zeroed one row per cycle, with
// req_stall high; register writes are taken during that pass.
// A stalled result is held in the output register; the next request may be
// accepted meanwhile and waits in its final step until the output is free.
module tabular_q_learning_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [tqle_pkg::RATE_W-1:0]   cfg_data,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  tqle_pkg::req_t                req,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output tqle_pkg::rsp_t                rsp
);

  tqle_pkg::state_t state;

  tqle_pkg::row_t mem [tqle_pkg::TABLE_ROWS];
  tqle_pkg::row_t rd_row;
  tqle_pkg::row_t wr_row;
  logic                             rd_en;
  logic [tqle_pkg::STATE_W-1:0]     rd_addr;
  logic                             mem_we;
  logic [tqle_pkg::STATE_W-1:0]     wr_addr;

  logic [tqle_pkg::RATE_W-1:0]      learn_rate;
  logic [tqle_pkg::RATE_W-1:0]      discount;
  logic [tqle_pkg::COUNT_W-1:0]     act_count;

  logic [tqle_pkg::STATE_W-1:0]     clr_cnt;

  logic [1:0]                       st_op;
  logic [tqle_pkg::STATE_W-1:0]     st_row;
  logic [tqle_pkg::ACTION_W-1:0]    st_act;
  logic signed [31:0]               st_reward;
  logic [tqle_pkg::ROW_SLOTS-1:0]   st_sel;
  logic                             st_err;

  logic [tqle_pkg::CHUNK_W-1:0]     chunk;
  logic                             found;
  logic signed [tqle_pkg::Q_W-1:0]  best_q;
  logic [tqle_pkg::ACTION_W-1:0]    best_a;
  logic                             s_found;
  logic signed [tqle_pkg::Q_W-1:0]  s_best;
  logic [tqle_pkg::ACTION_W-1:0]    s_act;

  logic signed [49:0]               prod_g;
  logic signed [tqle_pkg::Q_W-1:0]  target;
  logic signed [tqle_pkg::Q_W-1:0]  cur_q;
  logic signed [50:0]               prod_a;
  logic signed [tqle_pkg::Q_W-1:0]  new_q;
  logic signed [tqle_pkg::Q_W-1:0]  cur_sel;
  logic signed [32:0]               diff;

  tqle_pkg::rsp_t                   res;

  logic                             accept;
  logic                             out_free;
  logic [tqle_pkg::ROW_SLOTS-1:0]   all_mask;
  logic [tqle_pkg::ROW_SLOTS-1:0]   legal;
  logic [tqle_pkg::ROW_SLOTS-1:0]   sel_next;
  logic                             err_next;
  logic [tqle_pkg::COUNT_W-1:0]     cfg_count;

  assign req_stall = (state != tqle_pkg::S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    for (int a = 0; a < tqle_pkg::ROW_SLOTS; a++) begin
      all_mask[a] = (tqle_pkg::COUNT_W'(a) < act_count);
    end
    legal = req.legal_mask & all_mask;
    if (req.opcode == tqle_pkg::OP_MASKED && |legal) begin
      sel_next = legal;
    end else begin
      sel_next = all_mask;
    end
    err_next = (req.opcode inside {tqle_pkg::OP_UPDATE, tqle_pkg::OP_READ}) &&
               ({1'b0, req.action_index} >= act_count);
  end

  always_comb begin
    if (cfg_data[tqle_pkg::COUNT_W-1:0] == '0) begin
      cfg_count = tqle_pkg::COUNT_MIN;
    end else if (cfg_data[tqle_pkg::COUNT_W-1:0] > tqle_pkg::COUNT_MAX) begin
      cfg_count = tqle_pkg::COUNT_MAX;
    end else begin
      cfg_count = cfg_data[tqle_pkg::COUNT_W-1:0];
    end
  end

  always_comb begin
    logic [tqle_pkg::ACTION_W-1:0]   a;
    logic signed [tqle_pkg::Q_W-1:0] q;
    s_found = found;
    s_best  = best_q;
    s_act   = best_a;
    for (int j = 0; j < tqle_pkg::LANES; j++) begin
      a = {chunk, tqle_pkg::LANE_W'(j)};
      q = $signed(rd_row[a]);
      if (st_sel[a] && (!s_found || q > s_best)) begin
        s_found = 1'b1;
        s_best  = q;
        s_act   = a;
      end
    end
  end

  assign cur_sel = $signed(rd_row[st_act]);
  assign diff    = 33'(target) - 33'(cur_sel);
  assign new_q   = tqle_pkg::sat_q(36'(cur_q) + 36'($signed(prod_a[50:16])));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = st_row;
    mem_we  = 1'b0;
    wr_addr = st_row;
    wr_row  = rd_row;
    case (state)
      tqle_pkg::S_CLEAR: begin
        mem_we  = 1'b1;
        wr_addr = clr_cnt;
        wr_row  = '0;
      end
      tqle_pkg::S_IDLE: begin
        rd_en   = accept && !err_next;
        rd_addr = (req.opcode == tqle_pkg::OP_UPDATE) ? req.next_state_index
                                                      : req.state_index;
      end
      tqle_pkg::S_GMUL: begin
        rd_en = 1'b1;
      end
      tqle_pkg::S_WRITE: begin
        mem_we         = 1'b1;
        wr_row[st_act] = new_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_row <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate <= tqle_pkg::LEARN_RESET;
      discount   <= tqle_pkg::GAMMA_RESET;
      act_count  <= tqle_pkg::COUNT_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        tqle_pkg::CFG_LEARN: begin
          learn_rate <= cfg_data[tqle_pkg::RATE_W-1] ? tqle_pkg::RATE_ONE : cfg_data;
        end
        tqle_pkg::CFG_DISCOUNT: begin
          discount <= cfg_data[tqle_pkg::RATE_W-1] ? tqle_pkg::RATE_ONE : cfg_data;
        end
        tqle_pkg::CFG_ACTIONS: begin
          act_count <= cfg_count;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tqle_pkg::S_CLEAR;
      clr_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == tqle_pkg::S_DONE && out_free) begin
        rsp_valid <= 1'b1;
        rsp       <= res;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        tqle_pkg::S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == tqle_pkg::STATE_W'(tqle_pkg::TABLE_ROWS - 1)) begin
            state <= tqle_pkg::S_IDLE;
          end
        end
        tqle_pkg::S_IDLE: begin
          if (accept) begin
            st_op     <= req.opcode;
            st_row    <= req.state_index;
            st_act    <= req.action_index;
            st_reward <= req.reward_value;
            st_sel    <= sel_next;
            st_err    <= err_next;
            chunk     <= '0;
            found     <= 1'b0;
            best_q    <= '0;
            best_a    <= '0;
            if (err_next) begin
              res   <= '{chosen_action: '0, q_result: '0, error_flag: 1'b1};
              state <= tqle_pkg::S_DONE;
            end else if (req.opcode == tqle_pkg::OP_READ) begin
              state <= tqle_pkg::S_FETCH;
            end else begin
              state <= tqle_pkg::S_SCAN;
            end
          end
        end
        tqle_pkg::S_SCAN: begin
          found  <= s_found;
          best_q <= s_best;
          best_a <= s_act;
          chunk  <= chunk + 1'b1;
          if (chunk == '1) begin
            if (st_op == tqle_pkg::OP_UPDATE) begin
              state <= tqle_pkg::S_GMUL;
            end else begin
              res   <= '{chosen_action: s_act, q_result: s_best, error_flag: 1'b0};
              state <= tqle_pkg::S_DONE;
            end
          end
        end
        tqle_pkg::S_FETCH: begin
          res   <= '{chosen_action: '0, q_result: cur_sel, error_flag: 1'b0};
          state <= tqle_pkg::S_DONE;
        end
        tqle_pkg::S_GMUL: begin
          prod_g <= $signed({1'b0, discount}) * best_q;
          state  <= tqle_pkg::S_TGT;
        end
        tqle_pkg::S_TGT: begin
          target <= tqle_pkg::sat_q(36'(st_reward) + 36'($signed(prod_g[49:16])));
          state  <= tqle_pkg::S_AMUL;
        end
        tqle_pkg::S_AMUL: begin
          cur_q  <= cur_sel;
          prod_a <= $signed({1'b0, learn_rate}) * diff;
          state  <= tqle_pkg::S_WRITE;
        end
        tqle_pkg::S_WRITE: begin
          res   <= '{chosen_action: '0, q_result: new_q, error_flag: 1'b0};
          state <= tqle_pkg::S_DONE;
        end
        tqle_pkg::S_DONE: begin
          if (out_free) begin
            state <= tqle_pkg::S_IDLE;
          end
        end
        default: begin
          state <= tqle_pkg::S_IDLE;
        end
      endcase
    end
  end

  a_clear_stalls: assert property (@(posedge clk) disable iff (rst)
    state == tqle_pkg::S_CLEAR |-> req_stall)
    else $error("request taken during table clear");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == tqle_pkg::S_WRITE || state == tqle_pkg::S_CLEAR))
    else $error("table written outside clear or update write-back");

  a_no_err_write: assert property (@(posedge clk) disable iff (rst)
    state == tqle_pkg::S_WRITE |-> !st_err && st_op == tqle_pkg::OP_UPDATE)
    else $error("write-back for an erroneous or non-update word");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> req_stall)
    else $error("second word accepted while one is in flight");

  a_err_action: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.error_flag |-> rsp.chosen_action == '0 && rsp.q_result == '0)
    else $error("error result carries a value");

endmodule

[test/tb_tabular_q_learning_engine.sv]
// Self-checking testbench for tabular_q_learning_engine: directed and random
// request words checked against an in-bench Q table predictor.
// Depends on tqle_pkg and the engine RTL.
module tb_tabular_q_learning_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam longint Q_TOP    = 64'sd2147483647;
  localparam longint Q_BOTTOM = -64'sd2147483648;

  typedef enum int {RX_FREE, RX_SPARSE, RX_RUNS} rx_mode_t;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [1:0]                    cfg_index = '0;
  logic [tqle_pkg::RATE_W-1:0]   cfg_data = '0;
  logic                          req_valid = 1'b0;
  logic                          req_stall;
  tqle_pkg::req_t                req = '0;
  logic                          rsp_valid;
  logic                          rsp_stall = 1'b0;
  tqle_pkg::rsp_t                rsp;

  logic signed [tqle_pkg::Q_W-1:0] q_model [tqle_pkg::TABLE_ROWS][tqle_pkg::ROW_SLOTS];
  logic [tqle_pkg::RATE_W-1:0]     alpha_reg = tqle_pkg::LEARN_RESET;
  logic [tqle_pkg::RATE_W-1:0]     gamma_reg = tqle_pkg::GAMMA_RESET;
  logic [tqle_pkg::COUNT_W-1:0]    width_reg = tqle_pkg::COUNT_MAX;

  tqle_pkg::rsp_t awaited_rsp[$];
  int       mismatches = 0;
  int       burst_left = 0;
  bit       tx_gaps = 1'b1;
  rx_mode_t rx_mode = RX_SPARSE;
  int       hold_left = 0;
  int       run_left = 0;
  bit       run_stall = 1'b0;

  tabular_q_learning_engine DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL tabular_q_learning_engine");
    $finish;
  end

  initial begin
    foreach (q_model[s, a]) q_model[s][a] = '0;
  end

  function automatic longint clip_q(longint v);
    if (v > Q_TOP) return Q_TOP;
    if (v < Q_BOTTOM) return Q_BOTTOM;
    return v;
  endfunction

  function automatic int live_actions();
    int n;
    n = width_reg;
    if (n == 0) n = 1;
    if (n > tqle_pkg::ROW_SLOTS) n = tqle_pkg::ROW_SLOTS;
    return n;
  endfunction

  function automatic longint rate_val(logic [tqle_pkg::RATE_W-1:0] r);
    return (r > tqle_pkg::RATE_ONE) ? longint'(tqle_pkg::RATE_ONE) : longint'(r);
  endfunction

  function automatic logic [tqle_pkg::ACTION_W-1:0] row_best(int row, logic [15:0] sel,
                                                             int n, output longint best);
    logic [tqle_pkg::ACTION_W-1:0] best_a;
    bit found;
    longint q;
    best_a = '0;
    found = 1'b0;
    best = 0;
    for (int a = 0; a < n; a++) begin
      if (sel[a]) begin
        q = q_model[row][a];
        if (!found || q > best) begin
          best = q;
          best_a = tqle_pkg::ACTION_W'(a);
          found = 1'b1;
        end
      end
    end
    return best_a;
  endfunction

  function automatic tqle_pkg::rsp_t q_step(tqle_pkg::req_t w);
    tqle_pkg::rsp_t out;
    int n;
    logic [15:0] all, sel;
    longint nmax, target, cur, delta, res;
    n = live_actions();
    all = (n == 16) ? 16'hFFFF : ((16'd1 << n) - 16'd1);
    out = '0;
    res = 0;
    case (w.opcode)
      tqle_pkg::OP_UPDATE: begin
        if (w.action_index >= n) begin
          out.error_flag = 1'b1;
        end else begin
          void'(row_best(w.next_state_index, all, n, nmax));
          target = clip_q(longint'($signed(w.reward_value)) +
                          ((rate_val(gamma_reg) * nmax) >>> 16));
          cur = q_model[w.state_index][w.action_index];
          delta = (rate_val(alpha_reg) * (target - cur)) >>> 16;
          res = clip_q(cur + delta);
          q_model[w.state_index][w.action_index] = res[tqle_pkg::Q_W-1:0];
        end
      end
      tqle_pkg::OP_GREEDY, tqle_pkg::OP_MASKED: begin
        sel = all;
        if (w.opcode == tqle_pkg::OP_MASKED && (w.legal_mask & all) != 0) begin
          sel = w.legal_mask & all;
        end
        out.chosen_action = row_best(w.state_index, sel, n, res);
      end
      tqle_pkg::OP_READ: begin
        if (w.action_index >= n) out.error_flag = 1'b1;
        else res = q_model[w.state_index][w.action_index];
      end
      default: ;
    endcase
    out.q_result = res[tqle_pkg::Q_W-1:0];
    return out;
  endfunction

  function automatic tqle_pkg::req_t make_word(logic [1:0] op, logic [7:0] s, logic [3:0] a,
                                               logic [31:0] rew, logic [7:0] ns,
                                               logic [15:0] mask);
    tqle_pkg::req_t w;
    w.opcode = op;
    w.state_index = s;
    w.action_index = a;
    w.reward_value = rew;
    w.next_state_index = ns;
    w.legal_mask = mask;
    return w;
  endfunction

  function automatic logic [7:0] pick_row();
    return ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 7));
  endfunction

  function automatic logic [tqle_pkg::RATE_W-1:0] pick_rate();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return tqle_pkg::RATE_ONE;
      2: return 17'h1FFFF;
      default: return tqle_pkg::RATE_W'($urandom_range(0, 131071));
    endcase
  endfunction

  function automatic logic [tqle_pkg::COUNT_W-1:0] pick_count();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return tqle_pkg::COUNT_MAX;
      2: return 5'd31;
      3: return tqle_pkg::COUNT_MIN;
      default: return tqle_pkg::COUNT_W'($urandom_range(2, 16));
    endcase
  endfunction

  function automatic tqle_pkg::req_t random_word();
    tqle_pkg::req_t w;
    int pick;
    pick = $urandom_range(0, 9);
    w.opcode = (pick < 4) ? tqle_pkg::OP_UPDATE :
               (pick < 6) ? tqle_pkg::OP_GREEDY :
               (pick < 8) ? tqle_pkg::OP_MASKED : tqle_pkg::OP_READ;
    w.state_index = pick_row();
    w.next_state_index = pick_row();
    w.action_index = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                 : 4'($urandom_range(0, live_actions() - 1));
    case ($urandom_range(0, 5))
      0: w.reward_value = 32'($signed($urandom_range(0, 524288)) - 262144);
      1: w.reward_value = $urandom;
      2: w.reward_value = 32'h7FFFFFFF;
      3: w.reward_value = 32'h80000000;
      4: w.reward_value = 32'($signed($urandom_range(0, 40)) - 20) <<< 16;
      default: w.reward_value = 32'($urandom_range(0, 131072));
    endcase
    case ($urandom_range(0, 3))
      0: w.legal_mask = '0;
      1: w.legal_mask = 16'd1 << $urandom_range(0, 15);
      default: w.legal_mask = 16'($urandom);
    endcase
    return w;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [tqle_pkg::RATE_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tqle_pkg::CFG_LEARN:    alpha_reg = val;
      tqle_pkg::CFG_DISCOUNT: gamma_reg = val;
      tqle_pkg::CFG_ACTIONS:  width_reg = val[tqle_pkg::COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_word(tqle_pkg::req_t w);
    @(negedge clk);
    req <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    awaited_rsp.insert(awaited_rsp.size(), q_step(w));
    if (tx_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        @(negedge clk);
        req_valid <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic settle();
    @(negedge clk);
    req_valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // receiver stall pattern
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        case (rx_mode)
          RX_FREE:   rsp_stall <= 1'b0;
          RX_SPARSE: rsp_stall <= ($urandom_range(0, 3) == 0);
          default: begin
            if (run_left == 0) begin
              run_left = $urandom_range(1, 8);
              run_stall = !run_stall;
            end
            run_left--;
            rsp_stall <= run_stall;
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_rsp
    tqle_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited_rsp.size() == 0) begin
        $display("%0t unexpected word: chosen_action %0d q_result %0d error_flag %0d",
                 $time, rsp.chosen_action, $signed(rsp.q_result), rsp.error_flag);
        mismatches++;
      end else begin
        want = awaited_rsp.pop_front();
        if (rsp.chosen_action !== want.chosen_action) begin
          $display("%0t chosen_action expected %0d actual %0d",
                   $time, want.chosen_action, rsp.chosen_action);
          mismatches++;
        end
        if (rsp.q_result !== want.q_result) begin
          $display("%0t q_result expected %0d actual %0d",
                   $time, $signed(want.q_result), $signed(rsp.q_result));
          mismatches++;
        end
        if (rsp.error_flag !== want.error_flag) begin
          $display("%0t error_flag expected %0d actual %0d",
                   $time, want.error_flag, rsp.error_flag);
          mismatches++;
        end
      end
    end
  end

  task automatic test_directed();
    send_word(make_word(tqle_pkg::OP_UPDATE, 8'd0, 4'd0, 32'h00010000, 8'd0, 16'h0000));
    send_word(make_word(tqle_pkg::OP_READ, 8'd0, 4'd0, 32'h0, 8'd0, 16'h0000));
    send_word(make_word(tqle_pkg::OP_GREEDY, 8'd0, 4'd0, 32'h0, 8'd0, 16'h0000));
    settle();
    write_reg(tqle_pkg::CFG_LEARN, 17'h1FFFF);
    write_reg(tqle_pkg::CFG_DISCOUNT, 17'h1FFFF);
    write_reg(CFG_UNUSED, 17'h0ABCD);
    send_word(make_word(tqle_pkg::OP_UPDATE, 8'd1, 4'd15, 32'h7FFFFFFF, 8'd0, 16'h0000));
    send_word(make_word(tqle_pkg::OP_UPDATE, 8'd2, 4'd0, 32'h7FFFFFFF, 8'd1, 16'h0000));
    send_word(make_word(tqle_pkg::OP_UPDATE, 8'd3, 4'd5, 32'h80000000, 8'd3, 16'h0000));
    send_word(make_word(tqle_pkg::OP_UPDATE, 8'd3, 4'd6, 32'h80000000, 8'd3, 16'h0000));
    send_word(make_word(tqle_pkg::OP_GREEDY, 8'd3, 4'd0, 32'h0, 8'd0, 16'h0000));
    send_word(make_word(tqle_pkg::OP_MASKED, 8'd3, 4'd0, 32'h0, 8'd0, 16'h0060));
    send_word(make_word(tqle_pkg::OP_MASKED, 8'd1, 4'd0, 32'h0, 8'd0, 16'h0000));
    send_word(make_word(tqle_pkg::OP_MASKED, 8'd1, 4'd0, 32'h0, 8'd0, 16'h7FFF));
    send_word(make_word(tqle_pkg::OP_READ, 8'd1, 4'd15, 32'h0, 8'd0, 16'hFFFF));
    send_word(make_word(tqle_pkg::OP_UPDATE, 8'd255, 4'd15, 32'hFFFFFFFF, 8'd255, 16'hFFFF));
    send_word(make_word(tqle_pkg::OP_READ, 8'd255, 4'd15, 32'h0, 8'd0, 16'h0000));
  endtask

  task automatic test_action_limits();
    settle();
    write_reg(tqle_pkg::CFG_ACTIONS, 17'd0);
    send_word(make_word(tqle_pkg::OP_UPDATE, 8'd4, 4'd1, 32'h00050000, 8'd1, 16'h0000));
    send_word(make_word(tqle_pkg::OP_READ, 8'd4, 4'd1, 32'h0, 8'd0, 16'h0000));
    send_word(make_word(tqle_pkg::OP_UPDATE, 8'd4, 4'd0, 32'h00050000, 8'd1, 16'h0000));
    send_word(make_word(tqle_pkg::OP_GREEDY, 8'd1, 4'd0, 32'h0, 8'd0, 16'h0000));
    send_word(make_word(tqle_pkg::OP_MASKED, 8'd1, 4'd0, 32'h0, 8'd0, 16'h8000));
    settle();
    write_reg(tqle_pkg::CFG_ACTIONS, 17'd31);
    write_reg(tqle_pkg::CFG_LEARN, 17'd0);
    write_reg(tqle_pkg::CFG_DISCOUNT, 17'd0);
    send_word(make_word(tqle_pkg::OP_UPDATE, 8'd1, 4'd15, 32'h00000005, 8'd2, 16'h0000));
    send_word(make_word(tqle_pkg::OP_READ, 8'd1, 4'd15, 32'h0, 8'd0, 16'h0000));
    settle();
    write_reg(tqle_pkg::CFG_ACTIONS, 17'd5);
    write_reg(tqle_pkg::CFG_LEARN, tqle_pkg::RATE_ONE);
    write_reg(tqle_pkg::CFG_DISCOUNT, tqle_pkg::RATE_ONE);
    send_word(make_word(tqle_pkg::OP_MASKED, 8'd1, 4'd0, 32'h0, 8'd0, 16'hFFE0));
    send_word(make_word(tqle_pkg::OP_READ, 8'd1, 4'd5, 32'h0, 8'd0, 16'h0000));
    send_word(make_word(tqle_pkg::OP_UPDATE, 8'd2, 4'd4, 32'hFFFF0000, 8'd1, 16'h0000));
    send_word(make_word(tqle_pkg::OP_UPDATE, 8'd2, 4'd5, 32'h00010000, 8'd1, 16'h0000));
    send_word(make_word(tqle_pkg::OP_GREEDY, 8'd2, 4'd0, 32'h0, 8'd0, 16'h0000));
  endtask

  task automatic test_backpressure();
    settle();
    write_reg(tqle_pkg::CFG_ACTIONS, tqle_pkg::COUNT_MAX);
    rx_mode = RX_FREE;
    tx_gaps = 1'b0;
    hold_left = 80;
    repeat (24) send_word(random_word());
    settle();
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 6; phase++) begin
      settle();
      write_reg(tqle_pkg::CFG_LEARN, pick_rate());
      write_reg(tqle_pkg::CFG_DISCOUNT, pick_rate());
      write_reg(tqle_pkg::CFG_ACTIONS, pick_count());
      rx_mode = rx_mode_t'(phase % 3);
      tx_gaps = (phase % 2 == 0);
      for (int i = 0; i < 265; i++) begin
        if (phase == 1 && i == 130) settle();
        send_word(random_word());
      end
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_action_limits();
    test_backpressure();
    test_random();
    settle();
    if (mismatches == 0 && awaited_rsp.size() == 0) begin
      $display("PASS tabular_q_learning_engine");
    end else begin
      $display("FAIL tabular_q_learning_engine");
    end
    $finish;
  end

endmodule
